// ===== hdl/opp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the relation lookup for the precedence parser.
package opp_pkg;

    localparam int STACK_DEPTH_DEF   = 64;
    localparam int NUM_TERMINALS_DEF = 8;

    localparam int TOK_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int REL_WORD_W  = 64;
    localparam int REDS_W      = 7;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_REL_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_HIGH = 2'd1;

    localparam logic [TOK_W-1:0] TOK_END = 3'd0;

    typedef enum logic [1:0] {
        REL_NONE    = 2'd0,
        REL_LESS    = 2'd1,
        REL_EQUAL   = 2'd2,
        REL_GREATER = 2'd3
    } rel_t;

    typedef enum logic [1:0] {
        V_PENDING = 2'd0,
        V_ACCEPT  = 2'd1,
        V_REJECT  = 2'd2,
        V_IGNORED = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        C_NONE    = 3'd0,
        C_UNKNOWN = 3'd1,
        C_NOREL   = 3'd2,
        C_ENDED   = 3'd3,
        C_STACK   = 3'd4
    } cause_t;

    typedef struct packed {
        logic     load;
        logic     clear;
        logic     set_latch;
        logic     push;
        logic     reduce_base;
        logic     reduce_read;
        logic     walk_init;
        logic     walk_step;
        logic     finish;
        logic     out_load;
        verdict_t verdict;
        cause_t   cause;
    } opp_cmd_t;

    typedef struct packed {
        logic latch;
        logic unknown;
        logic is_end;
        logic accept_ok;
        rel_t top_rel;
        logic top_low;
        logic base_fail;
        logic full;
        logic walk_less;
        logic walk_last;
        logic read_fail;
    } opp_stat_t;

    function automatic rel_t rel_lookup(input logic [REL_WORD_W-1:0] lo,
                                        input logic [REL_WORD_W-1:0] hi,
                                        input logic [TOK_W-1:0]      row,
                                        input logic [TOK_W-1:0]      col);
        logic [REL_WORD_W-1:0] word;
        logic [5:0]            pos;
        word = row[2] ? hi : lo;
        pos  = {row[1:0], col, 1'b0};
        return rel_t'(word[pos +: 2]);
    endfunction

endpackage

// ===== hdl/opp_dp.sv =====
`timescale 1ns / 1ps
// Datapath: relation table, terminal stack memory, height and scan registers, result.
module opp_dp #(
    parameter int STACK_DEPTH   = opp_pkg::STACK_DEPTH_DEF,
    parameter int NUM_TERMINALS = opp_pkg::NUM_TERMINALS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [opp_pkg::TOK_W-1:0]        in_tok,
    input  logic                             in_unknown,
    input  logic                             cfg_we,
    input  logic [opp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [opp_pkg::REL_WORD_W-1:0]   cfg_data,
    input  opp_pkg::opp_cmd_t                cmd,
    output opp_pkg::opp_stat_t               stat,
    output logic [opp_pkg::OUT_TDATA_W-1:0]  out_data
);
    import opp_pkg::*;

    localparam int PW = $clog2(STACK_DEPTH);
    localparam int HW = $clog2(STACK_DEPTH + 1);
    localparam int SW = HW + 1;
    localparam int EW = PW + TOK_W;

    // Each stored terminal keeps its position in the symbol stack.
    logic [EW-1:0]         mem [STACK_DEPTH];
    logic [EW-1:0]         rd_reg;
    logic [PW-1:0]         rd_addr;
    logic [PW-1:0]         rd_pos;
    logic [TOK_W-1:0]      rd_tok;

    logic [REL_WORD_W-1:0] rel_lo_reg;
    logic [REL_WORD_W-1:0] rel_hi_reg;
    logic                  latch_reg;
    logic [HW-1:0]         height_reg;
    logic [PW-1:0]         top_idx_reg;
    logic [TOK_W-1:0]      top_tok_reg;
    logic [PW-1:0]         walk_idx_reg;
    logic [TOK_W-1:0]      cur_tok_reg;
    logic [TOK_W-1:0]      tok_reg;
    logic                  unk_reg;
    logic [REDS_W-1:0]     reds_reg;
    verdict_t              res_verdict_reg;
    cause_t                res_cause_reg;
    logic [REDS_W-1:0]     res_reds_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                  unknown;

    assign rd_pos  = rd_reg[EW-1:TOK_W];
    assign rd_tok  = rd_reg[TOK_W-1:0];
    assign rd_addr = cmd.walk_init ? PW'(top_idx_reg - PW'(1)) : PW'(walk_idx_reg - PW'(2));
    assign unknown = unk_reg || (32'(tok_reg) >= NUM_TERMINALS);

    always_comb begin
        stat.latch     = latch_reg;
        stat.unknown   = unknown;
        stat.is_end    = !unknown && (tok_reg == TOK_END);
        stat.accept_ok = (height_reg == HW'(2)) && (top_idx_reg == '0);
        stat.top_rel   = rel_lookup(rel_lo_reg, rel_hi_reg, top_tok_reg, tok_reg);
        stat.top_low   = top_idx_reg <= PW'(1);
        stat.base_fail = height_reg <= HW'(2);
        stat.full      = height_reg >= HW'(STACK_DEPTH);
        stat.walk_less = rel_lookup(rel_lo_reg, rel_hi_reg, rd_tok, cur_tok_reg) == REL_LESS;
        stat.walk_last = walk_idx_reg == PW'(2);
        stat.read_fail = (SW'(rd_pos) + SW'(2)) >= SW'(height_reg);
    end

    always_ff @(posedge aclk) begin
        rd_reg <= mem[rd_addr];
        if (cmd.push) begin
            mem[PW'(top_idx_reg + PW'(1))] <= {height_reg[PW-1:0], tok_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rel_lo_reg  <= '0;
            rel_hi_reg  <= '0;
            latch_reg   <= 1'b0;
            height_reg  <= HW'(1);
            top_idx_reg <= '0;
            top_tok_reg <= TOK_END;
        end else begin
            if (cfg_we && cfg_index == CFG_REL_LOW) begin
                rel_lo_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_REL_HIGH) begin
                rel_hi_reg <= cfg_data;
            end
            if (cmd.push) begin
                height_reg  <= HW'(height_reg + HW'(1));
                top_idx_reg <= PW'(top_idx_reg + PW'(1));
                top_tok_reg <= tok_reg;
            end
            if (cmd.reduce_base) begin
                height_reg  <= HW'(2);
                top_idx_reg <= '0;
                top_tok_reg <= TOK_END;
            end
            if (cmd.reduce_read) begin
                height_reg  <= HW'(SW'(rd_pos) + SW'(2));
                top_idx_reg <= PW'(walk_idx_reg - PW'(1));
                top_tok_reg <= rd_tok;
            end
            if (cmd.set_latch) begin
                latch_reg <= 1'b1;
            end
            if (cmd.clear) begin
                latch_reg   <= 1'b0;
                height_reg  <= HW'(1);
                top_idx_reg <= '0;
                top_tok_reg <= TOK_END;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tok_reg  <= in_tok;
            unk_reg  <= in_unknown;
            reds_reg <= '0;
        end else if (cmd.reduce_base || cmd.reduce_read) begin
            reds_reg <= REDS_W'(reds_reg + REDS_W'(1));
        end
        if (cmd.walk_init) begin
            walk_idx_reg <= top_idx_reg;
            cur_tok_reg  <= top_tok_reg;
        end else if (cmd.walk_step) begin
            walk_idx_reg <= PW'(walk_idx_reg - PW'(1));
            cur_tok_reg  <= rd_tok;
        end
        if (cmd.finish) begin
            res_verdict_reg <= cmd.verdict;
            res_cause_reg   <= cmd.cause;
            res_reds_reg    <= reds_reg;
        end
        if (cmd.out_load) begin
            out_data_reg <= OUT_TDATA_W'({res_reds_reg, res_cause_reg, res_verdict_reg});
        end
    end

    assign out_data = out_data_reg;

endmodule

// ===== hdl/opp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences compare, handle scan, reduce, shift and result hand-off.
module opp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                m_tready,
    output logic                m_tvalid,
    input  opp_pkg::opp_stat_t  stat,
    output opp_pkg::opp_cmd_t   cmd
);
    import opp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WALK,
        ST_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        cmd           = '0;
        cmd.verdict   = V_PENDING;
        cmd.cause     = C_NONE;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (stat.latch) begin
                    cmd.finish  = 1'b1;
                    cmd.verdict = V_IGNORED;
                    cmd.clear   = stat.is_end;
                end else if (stat.unknown) begin
                    cmd.finish  = 1'b1;
                    cmd.verdict = V_REJECT;
                    cmd.cause   = C_UNKNOWN;
                end else if (stat.is_end && stat.accept_ok) begin
                    cmd.finish  = 1'b1;
                    cmd.verdict = V_ACCEPT;
                end else begin
                    case (stat.top_rel)
                        REL_GREATER: begin
                            if (!stat.top_low) begin
                                cmd.walk_init = 1'b1;
                                state_next    = ST_WALK;
                            end else if (stat.base_fail) begin
                                cmd.finish  = 1'b1;
                                cmd.verdict = V_REJECT;
                                cmd.cause   = C_STACK;
                            end else begin
                                cmd.reduce_base = 1'b1;
                            end
                        end
                        REL_NONE: begin
                            cmd.finish  = 1'b1;
                            cmd.verdict = V_REJECT;
                            cmd.cause   = C_NOREL;
                        end
                        default: begin
                            cmd.finish = 1'b1;
                            if (stat.is_end) begin
                                cmd.verdict = V_REJECT;
                                cmd.cause   = C_ENDED;
                            end else if (stat.full) begin
                                cmd.verdict = V_REJECT;
                                cmd.cause   = C_STACK;
                            end else begin
                                cmd.push = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (stat.walk_less) begin
                    if (stat.read_fail) begin
                        cmd.finish  = 1'b1;
                        cmd.verdict = V_REJECT;
                        cmd.cause   = C_STACK;
                    end else begin
                        cmd.reduce_read = 1'b1;
                        state_next      = ST_EVAL;
                    end
                end else if (stat.walk_last) begin
                    if (stat.base_fail) begin
                        cmd.finish  = 1'b1;
                        cmd.verdict = V_REJECT;
                        cmd.cause   = C_STACK;
                    end else begin
                        cmd.reduce_base = 1'b1;
                        state_next      = ST_EVAL;
                    end
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_HOLD: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // An accepted parse resets; a rejected parse resets on the end marker, otherwise it is latched.
        if (cmd.finish) begin
            state_next = ST_HOLD;
            if (cmd.verdict == V_ACCEPT) begin
                cmd.clear = 1'b1;
            end
            if (cmd.verdict == V_REJECT) begin
                cmd.clear     = stat.is_end;
                cmd.set_latch = !stat.is_end;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== hdl/operator_precedence_parser.sv =====
`timescale 1ns / 1ps
// Top level of the shift-reduce operator precedence parser.
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_tvalid / s_tready | s_tdata: token_index; s_tuser: unknown_symbol
//  m_      | out       | m_tvalid / m_tready | m_tdata: verdict, reject_cause, reductions
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (relation rows)
//
// One token per transaction; the next token is taken after the result is parked in
// the output register. A token is accepted, compared once per pass (one pass per
// reduction and one more), then its result is handed off once; each stack memory read
// that the handle scans make is a further step.
// Reset is synchronous; the stack memory is not cleared, only its height and top.
// A stalled m_ side holds the finished result; the next token is still parsed, then
// waits at hand-off with s_tready low until the output register frees up.
module operator_precedence_parser #(
    parameter int STACK_DEPTH   = opp_pkg::STACK_DEPTH_DEF,
    parameter int NUM_TERMINALS = opp_pkg::NUM_TERMINALS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [opp_pkg::IN_TDATA_W-1:0]     s_tdata,   // [2:0] token_index
    input  logic                               s_tuser,   // [0] unknown_symbol
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [opp_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [1:0] verdict, [4:2] reject_cause,
                                                          // [11:5] reductions
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [opp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [opp_pkg::REL_WORD_W-1:0]     cfg_data
);
    import opp_pkg::*;

    opp_cmd_t  cmd;
    opp_stat_t stat;

    assign cfg_ready = 1'b1;

    opp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    opp_dp #(
        .STACK_DEPTH   (STACK_DEPTH),
        .NUM_TERMINALS (NUM_TERMINALS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_tok     (s_tdata[TOK_W-1:0]),
        .in_unknown (s_tuser),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .out_data   (m_tdata)
    );

endmodule

// ===== tb/tb_operator_precedence_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for operator_precedence_parser: directed table, then random token streams.
module tb_operator_precedence_parser;
    import opp_pkg::*;

    localparam int         DEPTH   = STACK_DEPTH_DEF;
    localparam int         NTERMS  = NUM_TERMINALS_DEF;
    localparam logic [3:0] NONTERM = 4'd8;

    localparam logic [2:0] T_PLUS  = 3'd1;
    localparam logic [2:0] T_MINUS = 3'd2;
    localparam logic [2:0] T_STAR  = 3'd3;
    localparam logic [2:0] T_SLASH = 3'd4;
    localparam logic [2:0] T_LPAR  = 3'd5;
    localparam logic [2:0] T_RPAR  = 3'd6;
    localparam logic [2:0] T_ID    = 3'd7;

    localparam logic [127:0] ALL_GREATER = {64{REL_GREATER}};
    localparam logic [127:0] ALL_LESS    = {64{REL_LESS}};

    typedef struct packed {
        verdict_t          verdict;
        cause_t            cause;
        logic [REDS_W-1:0] reds;
    } token_result_t;

    typedef struct {
        bit            is_load;
        logic [127:0]  grid;
        logic [2:0]    tok;
        bit            unk;
        bit            typed;
        token_result_t want;
    } step_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_REL_LOW;
    logic [REL_WORD_W-1:0]  cfg_data  = '0;

    // predictor state
    logic [3:0]   sym_stack [DEPTH];
    int           sym_depth   = 1;
    bit           skip_to_end = 1'b0;
    logic [127:0] rel_grid_now = '0;

    token_result_t pending_results[$];
    logic [3:0]    token_seq[$];
    step_row_t     dir_rows[$];
    int            sent   = 0;
    int            errors = 0;
    bit            calm   = 1'b0;

    operator_precedence_parser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int rel_pos(int r, int c);
        return 2 * (8 * r + c);
    endfunction

    function automatic rel_t grid_rel(logic [2:0] r, logic [2:0] c);
        return rel_t'(rel_grid_now[rel_pos(r, c) +: 2]);
    endfunction

    function automatic void clear_stack();
        sym_stack[0] = 4'd0;
        sym_depth    = 1;
        skip_to_end  = 1'b0;
    endfunction

    function automatic int top_term_pos();
        int i;
        i = sym_depth - 1;
        while (i > 0 && sym_stack[i] == NONTERM) i--;
        return i;
    endfunction

    // collapse the handle to one nonterminal; 0 if the stack would not shrink
    function automatic bit reduce_handle();
        int r;
        int l;
        int start;
        bit found;
        r     = top_term_pos();
        start = 1;
        found = 1'b0;
        while (!found) begin
            if (r == 0) begin
                start = 1;
                found = 1'b1;
            end else begin
                l = r - 1;
                while (l > 0 && sym_stack[l] == NONTERM) l--;
                if (grid_rel(sym_stack[l][2:0], sym_stack[r][2:0]) == REL_LESS) begin
                    start = l + 1;
                    found = 1'b1;
                end else begin
                    r = l;
                end
            end
        end
        if (start + 1 >= sym_depth) return 1'b0;
        sym_stack[start] = NONTERM;
        sym_depth        = start + 1;
        return 1'b1;
    endfunction

    function automatic token_result_t parse_token(logic [2:0] tok, bit unk);
        token_result_t res;
        bit            bad_sym;
        bit            is_end;
        bit            done;
        rel_t          rel;
        int            reds;
        res.verdict = V_PENDING;
        res.cause   = C_NONE;
        res.reds    = '0;
        reds        = 0;
        bad_sym     = unk || (int'(tok) >= NTERMS);
        is_end      = !bad_sym && tok == TOK_END;
        if (skip_to_end) begin
            if (is_end) clear_stack();
            res.verdict = V_IGNORED;
            return res;
        end
        if (bad_sym) begin
            res.verdict = V_REJECT;
            res.cause   = C_UNKNOWN;
        end else begin
            done = 1'b0;
            while (!done) begin
                done = 1'b1;
                if (is_end && sym_depth == 2 && sym_stack[1] == NONTERM) begin
                    res.verdict = V_ACCEPT;
                end else begin
                    rel = grid_rel(sym_stack[top_term_pos()][2:0], tok);
                    if (rel == REL_GREATER) begin
                        if (!reduce_handle()) begin
                            res.verdict = V_REJECT;
                            res.cause   = C_STACK;
                        end else begin
                            reds++;
                            done = 1'b0;
                        end
                    end else if (rel == REL_NONE) begin
                        res.verdict = V_REJECT;
                        res.cause   = C_NOREL;
                    end else if (is_end) begin
                        res.verdict = V_REJECT;
                        res.cause   = C_ENDED;
                    end else if (sym_depth >= DEPTH) begin
                        res.verdict = V_REJECT;
                        res.cause   = C_STACK;
                    end else begin
                        sym_stack[sym_depth] = {1'b0, tok};
                        sym_depth++;
                    end
                end
            end
        end
        if (is_end) clear_stack();
        else if (res.verdict == V_REJECT) skip_to_end = 1'b1;
        res.reds = reds[REDS_W-1:0];
        return res;
    endfunction

    // $ ( ) id around + - (low) and * / (high); right_assoc makes same-level ops shift
    function automatic logic [127:0] arith_grid(bit right_assoc);
        logic [127:0] g;
        bit           r_mul;
        bit           c_mul;
        g = '0;
        g[rel_pos(TOK_END, T_LPAR) +: 2] = REL_LESS;
        g[rel_pos(TOK_END, T_ID) +: 2]   = REL_LESS;
        g[rel_pos(T_LPAR, T_LPAR) +: 2]  = REL_LESS;
        g[rel_pos(T_LPAR, T_RPAR) +: 2]  = REL_EQUAL;
        g[rel_pos(T_LPAR, T_ID) +: 2]    = REL_LESS;
        g[rel_pos(T_RPAR, TOK_END) +: 2] = REL_GREATER;
        g[rel_pos(T_RPAR, T_RPAR) +: 2]  = REL_GREATER;
        g[rel_pos(T_ID, TOK_END) +: 2]   = REL_GREATER;
        g[rel_pos(T_ID, T_RPAR) +: 2]    = REL_GREATER;
        for (int r = T_PLUS; r <= T_SLASH; r++) begin
            g[rel_pos(TOK_END, r) +: 2] = REL_LESS;
            g[rel_pos(T_LPAR, r) +: 2]  = REL_LESS;
            g[rel_pos(T_RPAR, r) +: 2]  = REL_GREATER;
            g[rel_pos(T_ID, r) +: 2]    = REL_GREATER;
            g[rel_pos(r, TOK_END) +: 2] = REL_GREATER;
            g[rel_pos(r, T_RPAR) +: 2]  = REL_GREATER;
            g[rel_pos(r, T_LPAR) +: 2]  = REL_LESS;
            g[rel_pos(r, T_ID) +: 2]    = REL_EQUAL;
            r_mul = (r >= T_STAR);
            for (int c = T_PLUS; c <= T_SLASH; c++) begin
                c_mul = (c >= T_STAR);
                if (c_mul && !r_mul)
                    g[rel_pos(r, c) +: 2] = REL_LESS;
                else if (right_assoc && c_mul == r_mul)
                    g[rel_pos(r, c) +: 2] = REL_LESS;
                else
                    g[rel_pos(r, c) +: 2] = REL_GREATER;
            end
        end
        return g;
    endfunction

    function automatic void build_expr(int depth, int max_terms);
        int terms;
        terms = $urandom_range(1, max_terms);
        for (int i = 0; i < terms; i++) begin
            if (i > 0) token_seq.push_back({1'b0, 3'($urandom_range(T_PLUS, T_SLASH))});
            if (i > 0 && $urandom_range(0, 4) == 0) begin
                token_seq.push_back({1'b0, T_ID});
            end else if (depth == 0 || $urandom_range(0, 1) == 0) begin
                token_seq.push_back({1'b0, T_LPAR});
                token_seq.push_back({1'b0, T_RPAR});
            end else begin
                token_seq.push_back({1'b0, T_LPAR});
                build_expr(depth - 1, 3);
                token_seq.push_back({1'b0, T_RPAR});
            end
        end
    endfunction

    function automatic void corrupt_seq();
        int idx;
        if (token_seq.size() > 0 && $urandom_range(0, 7) == 0) begin
            idx            = $urandom_range(0, token_seq.size() - 1);
            token_seq[idx] = 4'($urandom);
        end
    endfunction

    function automatic void add_noise(bit always_end);
        repeat ($urandom_range(1, 10))
            token_seq.push_back({$urandom_range(0, 9) == 0, 3'($urandom)});
        if (always_end || $urandom_range(0, 3) != 0)
            token_seq.push_back({$urandom_range(0, 3) == 0, TOK_END});
    endfunction

    function automatic step_row_t row_tok(logic [2:0] tok, bit unk);
        step_row_t s;
        s.is_load = 1'b0;
        s.grid    = '0;
        s.tok     = tok;
        s.unk     = unk;
        s.typed   = 1'b0;
        s.want    = '0;
        return s;
    endfunction

    function automatic step_row_t row_exp(logic [2:0] tok, bit unk, verdict_t v, cause_t c);
        step_row_t s;
        s              = row_tok(tok, unk);
        s.typed        = 1'b1;
        s.want.verdict = v;
        s.want.cause   = c;
        return s;
    endfunction

    function automatic step_row_t row_grid(logic [127:0] g);
        step_row_t s;
        s         = row_tok(TOK_END, 1'b0);
        s.is_load = 1'b1;
        s.grid    = g;
        return s;
    endfunction

    task automatic send_token(input logic [2:0] tok, input bit unk, input bit typed,
                              input token_result_t fixed);
        token_result_t res;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - TOK_W){1'b0}}, tok};
        s_tuser  <= unk;
        do @(posedge aclk); while (!s_tready);
        res = parse_token(tok, unk);
        pending_results.push_back(typed ? fixed : res);
        sent++;
    endtask

    task automatic play_seq();
        foreach (token_seq[i]) send_token(token_seq[i][2:0], token_seq[i][3], 1'b0, '0);
        token_seq.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic load_grid(input logic [127:0] g);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_REL_LOW;
        cfg_data  <= g[63:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_REL_HIGH;
        cfg_data  <= g[127:64];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        rel_grid_now  = g;
    endtask

    // result side: random stalls, one long hold to back up the input
    initial begin : result_side
        int            stall_left;
        int            results;
        bit            held;
        token_result_t want;
        stall_left = 0;
        results    = 0;
        held       = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                results++;
                if (pending_results.size() == 0) begin
                    $error("result transaction with no expected result: tdata=%h", m_tdata);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[1:0] !== want.verdict) begin
                        $error("verdict: expected %0d, got %0d", want.verdict, m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[4:2] !== want.cause) begin
                        $error("reject_cause: expected %0d, got %0d", want.cause, m_tdata[4:2]);
                        errors++;
                    end
                    if (m_tdata[11:5] !== want.reds) begin
                        $error("reductions: expected %0d, got %0d", want.reds, m_tdata[11:5]);
                        errors++;
                    end
                end
            end
            if (!held && results >= 250) begin
                held       = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [127:0] g;
        int           kind;
        int           nest;
        int           stop;
        int           pick;
        bit           paused;
        paused = 1'b0;
        clear_stack();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        dir_rows = '{
            // zero table: no relations at all
            row_exp(T_STAR, 1'b0, V_REJECT, C_NOREL),
            row_exp(T_LPAR, 1'b0, V_IGNORED, C_NONE),
            row_exp(TOK_END, 1'b1, V_IGNORED, C_NONE),
            row_exp(T_ID, 1'b0, V_IGNORED, C_NONE),
            row_exp(TOK_END, 1'b0, V_IGNORED, C_NONE),
            row_exp(TOK_END, 1'b0, V_REJECT, C_NOREL),
            row_exp(TOK_END, 1'b1, V_REJECT, C_UNKNOWN),
            row_exp(TOK_END, 1'b0, V_IGNORED, C_NONE),
            // everything reduces: bare stack cannot shrink
            row_grid(ALL_GREATER),
            row_exp(T_ID, 1'b0, V_REJECT, C_STACK),
            row_exp(TOK_END, 1'b0, V_IGNORED, C_NONE),
            row_exp(TOK_END, 1'b0, V_REJECT, C_STACK),
            // everything shifts: end marker finds input ended
            row_grid(ALL_LESS),
            row_exp(T_PLUS, 1'b0, V_PENDING, C_NONE),
            row_exp(T_RPAR, 1'b0, V_PENDING, C_NONE),
            row_exp(TOK_END, 1'b0, V_REJECT, C_ENDED),
            row_grid(arith_grid(1'b0)),
            row_exp(T_LPAR, 1'b0, V_PENDING, C_NONE),
            row_exp(T_RPAR, 1'b0, V_PENDING, C_NONE),
            row_tok(TOK_END, 1'b0),
            row_exp(T_ID, 1'b0, V_PENDING, C_NONE),
            row_tok(T_MINUS, 1'b0),
            row_exp(TOK_END, 1'b0, V_IGNORED, C_NONE),
            row_tok(T_LPAR, 1'b0),
            row_tok(T_RPAR, 1'b0),
            row_tok(T_SLASH, 1'b0),
            row_tok(T_LPAR, 1'b0),
            row_tok(T_RPAR, 1'b0),
            row_tok(TOK_END, 1'b0),
            row_exp(T_MINUS, 1'b1, V_REJECT, C_UNKNOWN),
            row_exp(TOK_END, 1'b0, V_IGNORED, C_NONE)
        };
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_load)
                load_grid(dir_rows[i].grid);
            else
                send_token(dir_rows[i].tok, dir_rows[i].unk, dir_rows[i].typed,
                           dir_rows[i].want);
        end

        // expressions, deep nesting and noise on the arithmetic table
        while (sent < 950) begin
            if (!paused && sent >= 500) begin
                paused = 1'b1;
                drain();
            end
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                build_expr(2, 4);
                corrupt_seq();
                token_seq.push_back({1'b0, TOK_END});
            end else if (kind < 16) begin
                nest = $urandom_range(50, 66);
                repeat (nest) token_seq.push_back({1'b0, T_LPAR});
                repeat ($urandom_range(0, nest)) token_seq.push_back({1'b0, T_RPAR});
                token_seq.push_back({1'b0, TOK_END});
            end else begin
                add_noise(1'b0);
            end
            play_seq();
        end

        // weighted random relation tables
        repeat (4) begin
            for (int i = 0; i < 64; i++) begin
                pick = $urandom_range(0, 9);
                g[2*i +: 2] = (pick < 2) ? REL_NONE : (pick < 6) ? REL_LESS :
                              (pick == 6) ? REL_EQUAL : REL_GREATER;
            end
            load_grid(g);
            stop = sent + 100;
            while (sent < stop) begin
                add_noise(1'b1);
                play_seq();
            end
        end

        // right-associative table: long chains collapse on the end marker
        load_grid(arith_grid(1'b1));
        while (sent < 1550) begin
            if (sent >= 1400) calm = 1'b1;
            build_expr(1, ($urandom_range(0, 2) == 0) ? 30 : 5);
            corrupt_seq();
            token_seq.push_back({1'b0, TOK_END});
            play_seq();
        end

        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("** operator_precedence_parser: PASSED **");
        end else begin
            $display("** operator_precedence_parser: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("** operator_precedence_parser: FAILED **");
        $finish;
    end

endmodule
